// ===== rtl/traffic_rate_meter_top_defines.svh =====
// Assertion macros used by the traffic rate meter checker
`ifndef TRAFFIC_RATE_METER_TOP_DEFINES_SVH
`define TRAFFIC_RATE_METER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is high
`define TRM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that stays live through reset
`define TRM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/trm_pkg.sv =====
// Shared types and constants of the traffic rate meter
`default_nettype none
package trm_pkg;

   localparam logic [3:0] OP_ADD_SEND    = 4'd0;
   localparam logic [3:0] OP_ADD_RECV    = 4'd1;
   localparam logic [3:0] OP_START       = 4'd2;
   localparam logic [3:0] OP_PAUSE       = 4'd3;
   localparam logic [3:0] OP_RESUME      = 4'd4;
   localparam logic [3:0] OP_STOP        = 4'd5;
   localparam logic [3:0] OP_CLEAR       = 4'd6;
   localparam logic [3:0] OP_QUERY_SEND  = 4'd7;
   localparam logic [3:0] OP_QUERY_RECV  = 4'd8;
   localparam logic [3:0] OP_QUERY_TOTAL = 4'd9;

   localparam logic [1:0] MODE_STOP  = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_PAUSE = 2'd2;

   localparam logic [1:0] WIN_SEND  = 2'd0;
   localparam logic [1:0] WIN_RECV  = 2'd1;
   localparam logic [1:0] WIN_TOTAL = 2'd2;

   localparam int DEF_QUEUE_DEPTH = 2;

   localparam int          INTERVAL_W = 12;
   localparam int          THR_W      = 22;
   localparam logic [THR_W-1:0] THR_RESET = 22'd1000;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_ADD,
      KIND_START,
      KIND_PAUSE,
      KIND_RESUME,
      KIND_STOP,
      KIND_CLEAR,
      KIND_QUERY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   win;
      logic [31:0]  count;
      logic [47:0]  now_ms;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/trm_ifs.sv =====
// Request and response channel interfaces of the traffic rate meter
`default_nettype none
interface trm_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [31:0] count;
   logic [47:0] now_ms;

   modport source (output valid, output opcode, output count, output now_ms, input ready);
   modport sink (input valid, input opcode, input count, input now_ms, output ready);
endinterface

interface trm_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [31:0] rate;
   logic [1:0]  run_state;

   modport source (output valid, output accepted, output rate, output run_state, input ready);
   modport sink (input valid, input accepted, input rate, input run_state, output ready);
endinterface
`default_nettype wire

// ===== rtl/trm_front.sv =====
// Front end: accepts request transactions and classifies the opcode
`default_nettype none
module trm_front import trm_pkg::*; (
   trm_req_if.sink   req_bus,
   input  logic      full,
   output logic      push,
   output cmd_type   push_cmd
);

   always_comb begin
      push_cmd.count  = req_bus.count;
      push_cmd.now_ms = req_bus.now_ms;
      push_cmd.win    = WIN_SEND;
      case (req_bus.opcode)
         OP_ADD_SEND: begin
            push_cmd.kind = KIND_ADD;
         end
         OP_ADD_RECV: begin
            push_cmd.kind = KIND_ADD;
            push_cmd.win  = WIN_RECV;
         end
         OP_START:  push_cmd.kind = KIND_START;
         OP_PAUSE:  push_cmd.kind = KIND_PAUSE;
         OP_RESUME: push_cmd.kind = KIND_RESUME;
         OP_STOP:   push_cmd.kind = KIND_STOP;
         OP_CLEAR:  push_cmd.kind = KIND_CLEAR;
         OP_QUERY_SEND: begin
            push_cmd.kind = KIND_QUERY;
         end
         OP_QUERY_RECV: begin
            push_cmd.kind = KIND_QUERY;
            push_cmd.win  = WIN_RECV;
         end
         OP_QUERY_TOTAL: begin
            push_cmd.kind = KIND_QUERY;
            push_cmd.win  = WIN_TOTAL;
         end
         default: push_cmd.kind = KIND_NOP;
      endcase
   end

   assign req_bus.ready = !full;
   assign push          = req_bus.valid && !full;

endmodule
`default_nettype wire

// ===== rtl/trm_fifo.sv =====
// Command queue between the front end and the execution back end
`default_nettype none
module trm_fifo import trm_pkg::*; #(
   parameter int Depth = DEF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   cmd_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full    = (cnt_ff == FullCnt);
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/trm_back.sv =====
// Back end: run state, byte totals, rate windows and bit-serial divider
`default_nettype none
module trm_back import trm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [INTERVAL_W-1:0] csr_wr_data,
   input  logic                  empty,
   input  cmd_type               pop_cmd,
   output logic                  pop,
   trm_rsp_if.source             rsp_bus
);

   localparam int NumW = 74;
   localparam int CntW = $clog2(NumW);
   localparam logic [CntW-1:0] LastBit = CntW'(NumW - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CHECK,
      ST_SCALE,
      ST_DIV,
      ST_FINISH
   } state_type;

   function automatic logic [THR_W-1:0] sec_to_ms(input logic [INTERVAL_W-1:0] s);
      logic [THR_W-1:0] w;
      w = THR_W'(s);
      return (w << 10) - (w << 4) - (w << 3);
   endfunction

   state_type        state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [63:0]      send_total_ff, send_total_in;
   logic [63:0]      recv_total_ff, recv_total_in;
   logic [63:0]      byte_mark_ff [3];
   logic [63:0]      byte_mark_in [3];
   logic [47:0]      mark_time_ff [3];
   logic [47:0]      mark_time_in [3];
   logic [31:0]      held_rate_ff [3];
   logic [31:0]      held_rate_in [3];
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [1:0]       win_ff, win_in;
   logic [47:0]      now_ff, now_in;
   logic [63:0]      bytes_ff, bytes_in;
   logic [48:0]      diff_ff, diff_in;
   logic [63:0]      delta_ff, delta_in;
   logic [NumW-1:0]  num_ff, num_in;
   logic [47:0]      rem_ff, rem_in;
   logic [31:0]      quo_ff, quo_in;
   logic             ovf_ff, ovf_in;
   logic [CntW-1:0]  bit_cnt_ff, bit_cnt_in;
   logic             use_new_ff, use_new_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_accepted_ff, rsp_accepted_in;
   logic [31:0]      rsp_rate_ff, rsp_rate_in;
   logic [1:0]       rsp_state_ff, rsp_state_in;

   logic             out_free;
   logic             acc;
   logic [1:0]       mode_nx;
   logic [48:0]      trial;
   logic [48:0]      trial_sub;
   logic [NumW-1:0]  delta_ext;
   logic [31:0]      new_rate;

   assign out_free          = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.accepted  = rsp_accepted_ff;
   assign rsp_bus.rate      = rsp_rate_ff;
   assign rsp_bus.run_state = rsp_state_ff;

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      send_total_in   = send_total_ff;
      recv_total_in   = recv_total_ff;
      byte_mark_in    = byte_mark_ff;
      mark_time_in    = mark_time_ff;
      held_rate_in    = held_rate_ff;
      thr_in          = csr_wr_en ? sec_to_ms(csr_wr_data) : thr_ff;
      win_in          = win_ff;
      now_in          = now_ff;
      bytes_in        = bytes_ff;
      diff_in         = diff_ff;
      delta_in        = delta_ff;
      num_in          = num_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      ovf_in          = ovf_ff;
      bit_cnt_in      = bit_cnt_ff;
      use_new_in      = use_new_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_rate_in     = rsp_rate_ff;
      rsp_state_in    = rsp_state_ff;
      pop             = 1'b0;
      acc             = 1'b0;
      mode_nx         = mode_ff;
      trial           = {rem_ff, num_ff[NumW-1]};
      trial_sub       = trial - {1'b0, diff_ff[47:0]};
      delta_ext       = NumW'(delta_ff);
      new_rate        = ovf_ff ? 32'hFFFF_FFFF : quo_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!empty && out_free) begin
               pop = 1'b1;
               case (pop_cmd.kind)
                  KIND_ADD: begin
                     if (mode_ff == MODE_RUN) begin
                        if (pop_cmd.win == WIN_RECV) begin
                           recv_total_in = recv_total_ff + 64'(pop_cmd.count);
                        end else begin
                           send_total_in = send_total_ff + 64'(pop_cmd.count);
                        end
                     end
                  end
                  KIND_START: begin
                     if (mode_ff == MODE_STOP) begin
                        mode_nx = MODE_RUN;
                        acc     = 1'b1;
                     end
                  end
                  KIND_PAUSE: begin
                     if (mode_ff == MODE_RUN) begin
                        mode_nx = MODE_PAUSE;
                        acc     = 1'b1;
                     end
                  end
                  KIND_RESUME: begin
                     if (mode_ff == MODE_PAUSE) begin
                        mode_nx = MODE_RUN;
                        acc     = 1'b1;
                     end
                  end
                  KIND_STOP: begin
                     if (mode_ff == MODE_RUN) begin
                        mode_nx = MODE_STOP;
                        acc     = 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     send_total_in = '0;
                     recv_total_in = '0;
                     mode_nx       = MODE_STOP;
                     acc           = 1'b1;
                  end
                  KIND_QUERY: begin
                     win_in   = pop_cmd.win;
                     now_in   = pop_cmd.now_ms;
                     state_in = ST_DIFF;
                  end
                  default: begin
                  end
               endcase
               mode_in = mode_nx;
               if (pop_cmd.kind != KIND_QUERY) begin
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = acc;
                  rsp_rate_in     = '0;
                  rsp_state_in    = mode_nx;
               end
            end
         end
         ST_DIFF: begin
            case (win_ff)
               WIN_TOTAL: bytes_in = send_total_ff + recv_total_ff;
               WIN_RECV:  bytes_in = recv_total_ff;
               default:   bytes_in = send_total_ff;
            endcase
            diff_in  = {1'b0, now_ff} - {1'b0, mark_time_ff[win_ff]};
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (diff_ff[48] || (diff_ff[47:0] == '0) ||
                (diff_ff[47:0] < 48'(thr_ff))) begin
               use_new_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               delta_in   = bytes_ff - byte_mark_ff[win_ff];
               use_new_in = 1'b1;
               state_in   = ST_SCALE;
            end
         end
         ST_SCALE: begin
            num_in     = (delta_ext << 10) - (delta_ext << 4) - (delta_ext << 3);
            rem_in     = '0;
            quo_in     = '0;
            ovf_in     = 1'b0;
            bit_cnt_in = LastBit;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!trial_sub[48]) begin
               rem_in = trial_sub[47:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial[47:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            ovf_in = ovf_ff | quo_ff[31];
            num_in = num_ff << 1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = 1'b0;
               rsp_state_in    = mode_ff;
               if (use_new_ff) begin
                  rsp_rate_in          = new_rate;
                  held_rate_in[win_ff] = new_rate;
                  byte_mark_in[win_ff] = bytes_ff;
                  mark_time_in[win_ff] = now_ff;
               end else begin
                  rsp_rate_in = held_rate_ff[win_ff];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_STOP;
         send_total_ff <= '0;
         recv_total_ff <= '0;
         byte_mark_ff  <= '{default: '0};
         mark_time_ff  <= '{default: '0};
         held_rate_ff  <= '{default: '0};
         thr_ff        <= THR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         send_total_ff <= send_total_in;
         recv_total_ff <= recv_total_in;
         byte_mark_ff  <= byte_mark_in;
         mark_time_ff  <= mark_time_in;
         held_rate_ff  <= held_rate_in;
         thr_ff        <= thr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      win_ff          <= win_in;
      now_ff          <= now_in;
      bytes_ff        <= bytes_in;
      diff_ff         <= diff_in;
      delta_ff        <= delta_in;
      num_ff          <= num_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      ovf_ff          <= ovf_in;
      bit_cnt_ff      <= bit_cnt_in;
      use_new_ff      <= use_new_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_rate_ff     <= rsp_rate_in;
      rsp_state_ff    <= rsp_state_in;
   end

endmodule
`default_nettype wire

// ===== rtl/traffic_rate_meter_top.sv =====
// Top level of the traffic rate meter
//
//   channel   | direction | transaction
//   ----------+-----------+-------------------------------------------
//   req_bus   | in        | opcode, count, now_ms (valid/ready)
//   rsp_bus   | out       | accepted, rate, run_state (valid/ready)
//   csr_wr_*  | in        | interval_s write, no wait, no read-back
//
// Adds and control commands leave the back end the cycle after leaving the queue.
// A query whose window has not elapsed runs the diff, check and finish states; one
// that recomputes also runs scale and the one-bit-per-cycle 74-bit restoring divider.
// Until full, the queue takes new transactions while the back end works or the response stalls.
// Synchronous reset clears control state, totals and window marks; no clearing pass.
`default_nettype none
module traffic_rate_meter_top import trm_pkg::*; #(
   parameter int QueueDepth = DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   trm_req_if.sink               req_bus,
   trm_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [INTERVAL_W-1:0] csr_wr_data
);

   logic    push;
   cmd_type push_cmd;
   logic    full;
   logic    pop;
   cmd_type pop_cmd;
   logic    empty;

   trm_front u_front (
      .req_bus  (req_bus),
      .full     (full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   trm_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (empty)
   );

   trm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .empty       (empty),
      .pop_cmd     (pop_cmd),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== rtl/trm_checker.sv =====
// Port-level assertions for the traffic rate meter, bound to the top level
`default_nettype none
`include "traffic_rate_meter_top_defines.svh"
module trm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic [31:0] rsp_rate,
   input logic [1:0]  rsp_run_state
);

`TRM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rate) && $stable(rsp_accepted) && $stable(rsp_run_state), "response changed while stalled")
`TRM_ASSERT(a_cmd_no_rate, rsp_valid && rsp_accepted |-> rsp_rate == 32'd0, "accepted command carries a rate")
`TRM_ASSERT_RST(a_reset_quiet, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind traffic_rate_meter_top trm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_accepted  (rsp_bus.accepted),
   .rsp_rate      (rsp_bus.rate),
   .rsp_run_state (rsp_bus.run_state)
);
`default_nettype wire
